@@ hw/rtl/kfr_pkg.sv @@
// ----------------------------------------------------------------------------
// kfr_pkg: key state frame receiver package
// Payload structs, status and register codes, phase encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package kfr_pkg;

	localparam int PIN_W   = 64;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PIN_W-1:0] pin_states;
	} out_t;

	typedef struct packed {
		logic [7:0]  start_byte;
		logic [7:0]  key_command;
		logic [15:0] timeout_ticks;
		logic [6:0]  pin_count;
	} cfg_t;

	localparam logic [1:0] STATUS_PINS  = 2'd0;
	localparam logic [1:0] STATUS_DROP  = 2'd1;
	localparam logic [1:0] STATUS_FATAL = 2'd2;

	localparam logic       ACTION_BYTE = 1'b0;
	localparam logic       ACTION_TICK = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_COMMAND   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_COUNT     = 3'd3;

	localparam logic [7:0]  FATAL_COMMAND     = 8'hFF;
	localparam logic [7:0]  RST_START_BYTE    = 8'd0;
	localparam logic [7:0]  RST_KEY_COMMAND   = 8'd1;
	localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd3000;
	localparam logic [6:0]  RST_PIN_COUNT     = 7'd64;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'b001,
		PH_CMD     = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

endpackage

`default_nettype wire

@@ hw/rtl/kfr_core.sv @@
// ----------------------------------------------------------------------------
// kfr_core: frame parser
// Start byte hunt, command capture, payload assembly, tick timeout, halt.
// ----------------------------------------------------------------------------
`default_nettype none

module kfr_core #(
	parameter int PAYLOAD_BYTES = 8,
	parameter int MAX_PINS      = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire kfr_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	input  wire logic          in_stall,
	input  wire kfr_pkg::in_t  in_data,
	output logic               res_valid,
	output kfr_pkg::out_t      res
);
	import kfr_pkg::*;

	localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int PL_W  = PAYLOAD_BYTES * 8;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(PAYLOAD_BYTES - 1);

	phase_t            phase_q, phase_d;
	logic [7:0]        cmd_q, cmd_d;
	logic [IDX_W-1:0]  count_q, count_d;
	logic [15:0]       timer_q, timer_d;
	logic              halted_q, halted_d;
	logic [PL_W-1:0]   payload_q, payload_d;
	logic [15:0]       timer_inc;
	logic [6:0]        pins_eff;
	logic [PIN_W-1:0]  pin_mask;
	logic              accept;

	assign accept    = in_valid && !in_stall;
	assign timer_inc = timer_q + 16'd1;
	assign pins_eff  = (cfg.pin_count > 7'(MAX_PINS)) ? 7'(MAX_PINS) : cfg.pin_count;

	always_comb begin
		for (int i = 0; i < PIN_W; i++) begin
			pin_mask[i] = (7'(i) < pins_eff);
		end
	end

	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		count_d   = count_q;
		timer_d   = timer_q;
		halted_d  = halted_q;
		payload_d = payload_q;
		res_valid = 1'b0;
		res       = '0;
		if (accept && !halted_q) begin
			if (in_data.action == ACTION_TICK) begin
				if (phase_q != PH_HUNT) begin
					if (timer_inc >= cfg.timeout_ticks) begin
						phase_d    = PH_HUNT;
						timer_d    = '0;
						res_valid  = 1'b1;
						res.status = STATUS_DROP;
					end else begin
						timer_d = timer_inc;
					end
				end
			end else begin
				unique case (phase_q)
					PH_CMD: begin
						if (in_data.rx_byte == FATAL_COMMAND) begin
							halted_d   = 1'b1;
							phase_d    = PH_HUNT;
							res_valid  = 1'b1;
							res.status = STATUS_FATAL;
						end else begin
							cmd_d   = in_data.rx_byte;
							count_d = '0;
							timer_d = '0;
							phase_d = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						payload_d[count_q*8 +: 8] = in_data.rx_byte;
						if (count_q == LAST_SLOT) begin
							phase_d = PH_HUNT;
							count_d = '0;
							timer_d = '0;
							if (cmd_q == cfg.key_command) begin
								res_valid      = 1'b1;
								res.status     = STATUS_PINS;
								res.pin_states = PIN_W'(payload_d) & pin_mask;
							end
						end else begin
							count_d = count_q + IDX_W'(1);
						end
					end
					default: begin
						// hunting; also recovers from any illegal phase code
						phase_d = PH_HUNT;
						if (in_data.rx_byte == cfg.start_byte) begin
							phase_d = PH_CMD;
							timer_d = '0;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			cmd_q    <= '0;
			count_q  <= '0;
			timer_q  <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cmd_q    <= cmd_d;
			count_q  <= count_d;
			timer_q  <= timer_d;
			halted_q <= halted_d;
		end
	end

	// payload bytes are undefined until written
	always_ff @(posedge clk) begin
		payload_q <= payload_d;
	end

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	a_fatal_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == STATUS_FATAL) |=> (halted_q && phase_q == PH_HUNT))
		else $error("fatal command did not halt");

	a_no_result_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res_valid)
		else $error("result produced while halted");

endmodule

`default_nettype wire

@@ hw/rtl/kfr_out_buf.sv @@
// ----------------------------------------------------------------------------
// kfr_out_buf: result register with skid stage
// Holds results while the sink stalls; stalls the parser only when full.
// ----------------------------------------------------------------------------
`default_nettype none

module kfr_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire kfr_pkg::out_t push_data,
	output logic               full,
	output logic               out_valid,
	input  wire logic          out_stall,
	output kfr_pkg::out_t      out_data
);
	import kfr_pkg::*;

	logic main_valid_q, skid_valid_q;
	out_t main_q, skid_q;
	logic pop, main_free;

	assign pop       = main_valid_q && !out_stall;
	assign main_free = pop || !main_valid_q;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_valid_q))
		else $error("transaction pushed into full buffer");

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid stage holds data with main register empty");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && pop) |=> (main_valid_q && !skid_valid_q))
		else $error("skid transaction lost on pop");

endmodule

`default_nettype wire

@@ hw/rtl/key_state_frame_receiver_top.sv @@
// ----------------------------------------------------------------------------
// key_state_frame_receiver_top: key state frame receiver
// Parses start/command/payload frames from serial bytes and ms ticks.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------
//  in       | in  | in_valid / in_stall  | in_data  (action, rx_byte)
//  out      | out | out_valid / out_stall| out_data (status, pin_states)
//  cfg      | in  | cfg_we               | cfg_index, cfg_data
//
//  One input transaction per cycle while in_stall is low; each result is
//  registered in the main result register, or in the skid stage if that is busy.
//  A skid stage lets input continue while one result waits; in_stall rises
//  only when two results are held.
//  arst_n clears frame state, halt and registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module key_state_frame_receiver_top #(
	parameter int PAYLOAD_BYTES = 8,
	parameter int MAX_PINS      = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire kfr_pkg::in_t                    in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output kfr_pkg::out_t                        out_data,
	input  wire logic                            cfg_we,
	input  wire logic [kfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kfr_pkg::CFG_W-1:0]       cfg_data
);
	import kfr_pkg::*;

	cfg_t cfg_q;
	logic res_valid;
	out_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= RST_START_BYTE;
			cfg_q.key_command   <= RST_KEY_COMMAND;
			cfg_q.timeout_ticks <= RST_TIMEOUT_TICKS;
			cfg_q.pin_count     <= RST_PIN_COUNT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_BYTE:    cfg_q.start_byte    <= cfg_data[7:0];
				CFG_KEY_COMMAND:   cfg_q.key_command   <= cfg_data[7:0];
				CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data[15:0];
				CFG_PIN_COUNT:     cfg_q.pin_count     <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	kfr_core #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.MAX_PINS      (MAX_PINS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res       (res)
	);

	kfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
